// File: hw/rtl/sfra_pkg.sv
// Shared constants, types and the bin helper function of the segregated-fit region allocator.
package sfra_pkg;

    localparam int REGION_BYTES       = 65536;
    localparam int ALIGN_BYTES        = 16;
    localparam int MEM_HEADER_BYTES   = 64;
    localparam int BLOCK_HEADER_BYTES = 48;
    localparam int BIN_COUNT          = 16;

    localparam int MIN_SPLIT       = 256;
    localparam int FIRST_BIN_LIMIT = 512;

    localparam int SLOTS    = REGION_BYTES / ALIGN_BYTES;
    localparam int POFF     = (BLOCK_HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;
    localparam int ALIGN_SH = $clog2(ALIGN_BYTES);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int LINK_W = SLOT_W + 1;
    localparam int SIZE_W = $clog2(REGION_BYTES) + 1;
    localparam int NEED_W = 33;
    localparam int BIN_W  = $clog2(BIN_COUNT);
    localparam int KCNT_W = BIN_W + 1;
    localparam int STEP_W = LINK_W;
    localparam int REQ_W  = 32;
    localparam int OFF_W  = 16;
    localparam int STAT_W = 2;

    localparam logic [LINK_W-1:0] NIL = LINK_W'(SLOTS);

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_ZERO  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOFIT = 2'd2;

    // Operation codes carried in tuser.
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef logic [4:0] t_cmd;

    localparam t_cmd CMD_IDLE      = 5'd0;
    localparam t_cmd CMD_LOAD      = 5'd1;
    localparam t_cmd CMD_FORMAT    = 5'd2;
    localparam t_cmd CMD_SEEK_INIT = 5'd3;
    localparam t_cmd CMD_SEEK_BIN  = 5'd4;
    localparam t_cmd CMD_READ_CUR  = 5'd5;
    localparam t_cmd CMD_SEEK_ADV  = 5'd6;
    localparam t_cmd CMD_FOUND     = 5'd7;
    localparam t_cmd CMD_UL_INIT   = 5'd8;
    localparam t_cmd CMD_UL_ADV    = 5'd9;
    localparam t_cmd CMD_UL_HIT    = 5'd10;
    localparam t_cmd CMD_UL_CLR    = 5'd11;
    localparam t_cmd CMD_MARK_USED = 5'd12;
    localparam t_cmd CMD_CARVE_NEW = 5'd13;
    localparam t_cmd CMD_CARVE_FIX = 5'd14;
    localparam t_cmd CMD_PUSH      = 5'd15;
    localparam t_cmd CMD_READ_B    = 5'd16;
    localparam t_cmd CMD_F_MARK    = 5'd17;
    localparam t_cmd CMD_READ_LEFT = 5'd18;
    localparam t_cmd CMD_L_TAKE    = 5'd19;
    localparam t_cmd CMD_L_MERGE   = 5'd20;
    localparam t_cmd CMD_READ_RGT  = 5'd21;
    localparam t_cmd CMD_R_TAKE    = 5'd22;
    localparam t_cmd CMD_R_MERGE   = 5'd23;
    localparam t_cmd CMD_RES_ZERO  = 5'd24;
    localparam t_cmd CMD_RES_NOFIT = 5'd25;
    localparam t_cmd CMD_EMIT      = 5'd26;

    typedef struct packed {
        logic walk_end;
        logic k_last;
        logic fit;
        logic hit;
        logic rd_free;
        logic left_ok;
        logic right_ok;
        logic can_split;
        logic free_ok;
        logic is_free;
        logic req_zero;
        logic ready;
        logic slot_free;
    } t_sts;

    // Bin i holds sizes up to FIRST_BIN_LIMIT << i; the last bin takes the rest.
    function automatic logic [BIN_W-1:0] bin_of(input logic [NEED_W-1:0] sz);
        logic [BIN_W-1:0] k;
        k = BIN_W'(BIN_COUNT - 1);
        for (int i = BIN_COUNT - 2; i >= 0; i--) begin
            if ({31'd0, sz} <= (64'(FIRST_BIN_LIMIT) << i)) begin
                k = BIN_W'(i);
            end
        end
        return k;
    endfunction

endpackage

// File: hw/rtl/sfra_ctrl.sv
// Sequencing state machine of the segregated-fit region allocator.
module sfra_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  sfra_pkg::t_sts    i_sts,
    output logic              o_in_ready,
    output sfra_pkg::t_cmd    o_cmd
);

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_DISPATCH  = 5'd1;
    localparam logic [4:0] S_SEEK_INIT = 5'd2;
    localparam logic [4:0] S_SEEK_TEST = 5'd3;
    localparam logic [4:0] S_SEEK_CHK  = 5'd4;
    localparam logic [4:0] S_UL_INIT   = 5'd5;
    localparam logic [4:0] S_UL_TEST   = 5'd6;
    localparam logic [4:0] S_UL_CHK    = 5'd7;
    localparam logic [4:0] S_UL_CLR    = 5'd8;
    localparam logic [4:0] S_MARK_USED = 5'd9;
    localparam logic [4:0] S_CARVE_NEW = 5'd10;
    localparam logic [4:0] S_CARVE_FIX = 5'd11;
    localparam logic [4:0] S_PUSH      = 5'd12;
    localparam logic [4:0] S_F_READ    = 5'd13;
    localparam logic [4:0] S_F_CHK     = 5'd14;
    localparam logic [4:0] S_L_TEST    = 5'd15;
    localparam logic [4:0] S_L_CHK     = 5'd16;
    localparam logic [4:0] S_L_MERGE   = 5'd17;
    localparam logic [4:0] S_R_TEST    = 5'd18;
    localparam logic [4:0] S_R_CHK     = 5'd19;
    localparam logic [4:0] S_R_MERGE   = 5'd20;
    localparam logic [4:0] S_RESULT    = 5'd21;

    logic [4:0] r_state, n_state;
    logic [4:0] r_ret, n_ret;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        o_cmd   = sfra_pkg::CMD_IDLE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = sfra_pkg::CMD_LOAD;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_sts.is_free) begin
                    n_state = i_sts.free_ok ? S_F_READ : S_RESULT;
                end else if (i_sts.req_zero) begin
                    o_cmd   = sfra_pkg::CMD_RES_ZERO;
                    n_state = S_RESULT;
                end else begin
                    if (!i_sts.ready) begin
                        o_cmd = sfra_pkg::CMD_FORMAT;
                    end
                    n_state = S_SEEK_INIT;
                end
            end
            S_SEEK_INIT: begin
                o_cmd   = sfra_pkg::CMD_SEEK_INIT;
                n_state = S_SEEK_TEST;
            end
            S_SEEK_TEST: begin
                if (i_sts.walk_end) begin
                    if (i_sts.k_last) begin
                        o_cmd   = sfra_pkg::CMD_RES_NOFIT;
                        n_state = S_RESULT;
                    end else begin
                        o_cmd = sfra_pkg::CMD_SEEK_BIN;
                    end
                end else begin
                    o_cmd   = sfra_pkg::CMD_READ_CUR;
                    n_state = S_SEEK_CHK;
                end
            end
            S_SEEK_CHK: begin
                if (i_sts.fit) begin
                    o_cmd   = sfra_pkg::CMD_FOUND;
                    n_ret   = S_MARK_USED;
                    n_state = S_UL_INIT;
                end else begin
                    o_cmd   = sfra_pkg::CMD_SEEK_ADV;
                    n_state = S_SEEK_TEST;
                end
            end
            S_UL_INIT: begin
                o_cmd   = sfra_pkg::CMD_UL_INIT;
                n_state = S_UL_TEST;
            end
            S_UL_TEST: begin
                if (i_sts.walk_end) begin
                    n_state = r_ret;
                end else begin
                    o_cmd   = sfra_pkg::CMD_READ_CUR;
                    n_state = S_UL_CHK;
                end
            end
            S_UL_CHK: begin
                if (i_sts.hit) begin
                    o_cmd   = sfra_pkg::CMD_UL_HIT;
                    n_state = S_UL_CLR;
                end else begin
                    o_cmd   = sfra_pkg::CMD_UL_ADV;
                    n_state = S_UL_TEST;
                end
            end
            S_UL_CLR: begin
                o_cmd   = sfra_pkg::CMD_UL_CLR;
                n_state = r_ret;
            end
            S_MARK_USED: begin
                o_cmd   = sfra_pkg::CMD_MARK_USED;
                n_state = i_sts.can_split ? S_CARVE_NEW : S_RESULT;
            end
            S_CARVE_NEW: begin
                o_cmd   = sfra_pkg::CMD_CARVE_NEW;
                n_state = S_CARVE_FIX;
            end
            S_CARVE_FIX: begin
                o_cmd   = sfra_pkg::CMD_CARVE_FIX;
                n_state = S_PUSH;
            end
            S_PUSH: begin
                o_cmd   = sfra_pkg::CMD_PUSH;
                n_state = S_RESULT;
            end
            S_F_READ: begin
                o_cmd   = sfra_pkg::CMD_READ_B;
                n_state = S_F_CHK;
            end
            S_F_CHK: begin
                if (i_sts.rd_free) begin
                    n_state = S_RESULT;
                end else begin
                    o_cmd   = sfra_pkg::CMD_F_MARK;
                    n_state = S_L_TEST;
                end
            end
            S_L_TEST: begin
                if (i_sts.left_ok) begin
                    o_cmd   = sfra_pkg::CMD_READ_LEFT;
                    n_state = S_L_CHK;
                end else begin
                    n_state = S_R_TEST;
                end
            end
            S_L_CHK: begin
                if (i_sts.rd_free) begin
                    o_cmd   = sfra_pkg::CMD_L_TAKE;
                    n_ret   = S_L_MERGE;
                    n_state = S_UL_INIT;
                end else begin
                    n_state = S_R_TEST;
                end
            end
            S_L_MERGE: begin
                o_cmd   = sfra_pkg::CMD_L_MERGE;
                n_state = S_R_TEST;
            end
            S_R_TEST: begin
                if (i_sts.right_ok) begin
                    o_cmd   = sfra_pkg::CMD_READ_RGT;
                    n_state = S_R_CHK;
                end else begin
                    n_state = S_PUSH;
                end
            end
            S_R_CHK: begin
                if (i_sts.rd_free) begin
                    o_cmd   = sfra_pkg::CMD_R_TAKE;
                    n_ret   = S_R_MERGE;
                    n_state = S_UL_INIT;
                end else begin
                    n_state = S_PUSH;
                end
            end
            S_R_MERGE: begin
                o_cmd   = sfra_pkg::CMD_R_MERGE;
                n_state = S_PUSH;
            end
            S_RESULT: begin
                if (i_sts.slot_free) begin
                    o_cmd   = sfra_pkg::CMD_EMIT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/sfra_dp.sv
// Datapath of the segregated-fit region allocator: block records, bin heads and result register.
module sfra_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  sfra_pkg::t_cmd                  i_cmd,
    input  logic                            i_func,
    input  logic [sfra_pkg::REQ_W-1:0]      i_req,
    input  logic [sfra_pkg::OFF_W-1:0]      i_off,
    input  logic                            i_out_ready,
    output sfra_pkg::t_sts                  o_sts,
    output logic                            o_out_valid,
    output logic [sfra_pkg::STAT_W-1:0]     o_status,
    output logic [sfra_pkg::OFF_W-1:0]      o_hoff
);

    localparam int SW = sfra_pkg::SLOT_W;
    localparam int LW = sfra_pkg::LINK_W;
    localparam int ZW = sfra_pkg::SIZE_W;
    localparam int NW = sfra_pkg::NEED_W;

    // Block record memories, one write and one read port each.
    logic [ZW-1:0] mem_bytes [sfra_pkg::SLOTS];
    logic [LW-1:0] mem_prev  [sfra_pkg::SLOTS];
    logic [LW-1:0] mem_next  [sfra_pkg::SLOTS];
    logic [LW-1:0] mem_link  [sfra_pkg::SLOTS];
    logic          mem_free  [sfra_pkg::SLOTS];

    logic [LW-1:0] r_heads [sfra_pkg::BIN_COUNT];
    logic          r_ready;

    logic                         r_func, r_req_zero, r_free_ok;
    logic [NW-1:0]                r_need;
    logic [SW-1:0]                r_b;
    logic [ZW-1:0]                r_bb, r_xs;
    logic [LW-1:0]                r_bnext, r_left, r_cur, r_before, r_x, r_rn;
    logic [sfra_pkg::KCNT_W-1:0]  r_k;
    logic [sfra_pkg::STEP_W-1:0]  r_steps;
    logic [sfra_pkg::STAT_W-1:0]  r_status;
    logic [sfra_pkg::OFF_W-1:0]   r_hoff;
    logic                         r_ovalid;
    logic [sfra_pkg::STAT_W-1:0]  r_ostat;
    logic [sfra_pkg::OFF_W-1:0]   r_ohoff;

    logic [ZW-1:0] r_rd_bytes;
    logic [LW-1:0] r_rd_prev, r_rd_next, r_rd_link;
    logic          r_rd_free;

    logic [SW-1:0] w_ra;
    logic          w_bytes_we, w_prev_we, w_next_we, w_link_we, w_free_we;
    logic [SW-1:0] w_bytes_wa, w_prev_wa, w_next_wa, w_link_wa, w_free_wa;
    logic [ZW-1:0] w_bytes_wd;
    logic [LW-1:0] w_prev_wd, w_next_wd, w_link_wd;
    logic          w_free_wd;

    logic [NW-1:0]     w_need, w_nb_sum;
    logic [SW-1:0]     w_nb;
    logic [ZW-1:0]     w_nb_size, w_lsum, w_rsum;
    logic [sfra_pkg::BIN_W-1:0] w_k_push, w_k_ul, w_k_need;
    logic [sfra_pkg::OFF_W-1:0] w_off_rel;

    assign w_need    = ((NW'(i_req) + NW'(sfra_pkg::MEM_HEADER_BYTES + sfra_pkg::ALIGN_BYTES - 1))
                        >> sfra_pkg::ALIGN_SH) << sfra_pkg::ALIGN_SH;
    assign w_off_rel = i_off - sfra_pkg::OFF_W'(sfra_pkg::POFF);
    assign w_nb_sum  = NW'(r_b) + NW'(sfra_pkg::POFF / sfra_pkg::ALIGN_BYTES)
                       + (r_need >> sfra_pkg::ALIGN_SH);
    assign w_nb      = w_nb_sum[SW-1:0];
    assign w_nb_size = ZW'(NW'(r_bb) - r_need - NW'(sfra_pkg::POFF));
    assign w_lsum    = r_xs + ZW'(sfra_pkg::POFF) + r_bb;
    assign w_rsum    = r_bb + ZW'(sfra_pkg::POFF) + r_xs;
    assign w_k_push  = sfra_pkg::bin_of(NW'(r_bb));
    assign w_k_ul    = sfra_pkg::bin_of(NW'(r_xs));
    assign w_k_need  = sfra_pkg::bin_of(r_need);

    always_comb begin
        o_sts.walk_end  = (r_cur >= sfra_pkg::NIL)
                          || (r_steps > sfra_pkg::STEP_W'(sfra_pkg::SLOTS));
        o_sts.k_last    = (r_k == sfra_pkg::KCNT_W'(sfra_pkg::BIN_COUNT - 1));
        o_sts.fit       = r_rd_free && (NW'(r_rd_bytes) >= r_need);
        o_sts.hit       = (r_cur == r_x);
        o_sts.rd_free   = r_rd_free;
        o_sts.left_ok   = (r_left < sfra_pkg::NIL);
        o_sts.right_ok  = (r_bnext < sfra_pkg::NIL);
        o_sts.can_split = (NW'(r_bb) >= r_need + NW'(sfra_pkg::POFF + sfra_pkg::MIN_SPLIT))
                          && (w_nb_sum < NW'(sfra_pkg::SLOTS));
        o_sts.free_ok   = r_free_ok;
        o_sts.is_free   = (r_func == sfra_pkg::FUNC_FREE);
        o_sts.req_zero  = r_req_zero;
        o_sts.ready     = r_ready;
        o_sts.slot_free = !r_ovalid || i_out_ready;
    end

    // Memory port selection per command.
    always_comb begin
        w_ra       = r_cur[SW-1:0];
        w_bytes_we = 1'b0; w_bytes_wa = r_b; w_bytes_wd = r_bb;
        w_prev_we  = 1'b0; w_prev_wa  = r_b; w_prev_wd  = sfra_pkg::NIL;
        w_next_we  = 1'b0; w_next_wa  = r_b; w_next_wd  = sfra_pkg::NIL;
        w_link_we  = 1'b0; w_link_wa  = r_b; w_link_wd  = sfra_pkg::NIL;
        w_free_we  = 1'b0; w_free_wa  = r_b; w_free_wd  = 1'b0;
        case (i_cmd)
            sfra_pkg::CMD_READ_B:    w_ra = r_b;
            sfra_pkg::CMD_READ_LEFT: w_ra = r_left[SW-1:0];
            sfra_pkg::CMD_READ_RGT:  w_ra = r_bnext[SW-1:0];
            sfra_pkg::CMD_FORMAT: begin
                w_bytes_we = 1'b1; w_bytes_wa = '0;
                w_bytes_wd = ZW'(sfra_pkg::REGION_BYTES - sfra_pkg::POFF);
                w_prev_we  = 1'b1; w_prev_wa = '0;
                w_next_we  = 1'b1; w_next_wa = '0;
                w_link_we  = 1'b1; w_link_wa = '0;
                w_free_we  = 1'b1; w_free_wa = '0; w_free_wd = 1'b1;
            end
            sfra_pkg::CMD_UL_HIT: begin
                w_link_we = (r_before < sfra_pkg::NIL);
                w_link_wa = r_before[SW-1:0];
                w_link_wd = r_rd_link;
            end
            sfra_pkg::CMD_UL_CLR: begin
                w_link_we = 1'b1;
                w_link_wa = r_x[SW-1:0];
            end
            sfra_pkg::CMD_MARK_USED: begin
                w_free_we = 1'b1;
            end
            sfra_pkg::CMD_CARVE_NEW: begin
                w_bytes_we = 1'b1; w_bytes_wa = w_nb; w_bytes_wd = w_nb_size;
                w_prev_we  = 1'b1; w_prev_wa  = w_nb; w_prev_wd  = LW'(r_b);
                w_next_we  = 1'b1; w_next_wa  = w_nb; w_next_wd  = r_bnext;
                w_link_we  = 1'b1; w_link_wa  = w_nb;
                w_free_we  = 1'b1; w_free_wa  = w_nb; w_free_wd  = 1'b1;
            end
            sfra_pkg::CMD_CARVE_FIX: begin
                w_prev_we  = (r_bnext < sfra_pkg::NIL);
                w_prev_wa  = r_bnext[SW-1:0];
                w_prev_wd  = LW'(w_nb);
                w_next_we  = 1'b1; w_next_wd = LW'(w_nb);
                w_bytes_we = 1'b1; w_bytes_wd = r_need[ZW-1:0];
            end
            sfra_pkg::CMD_PUSH: begin
                w_link_we = 1'b1;
                w_link_wd = r_heads[w_k_push];
            end
            sfra_pkg::CMD_F_MARK: begin
                w_free_we = 1'b1; w_free_wd = 1'b1;
                w_link_we = 1'b1;
            end
            sfra_pkg::CMD_L_MERGE: begin
                w_bytes_we = 1'b1; w_bytes_wa = r_left[SW-1:0]; w_bytes_wd = w_lsum;
                w_next_we  = 1'b1; w_next_wa  = r_left[SW-1:0]; w_next_wd  = r_bnext;
                w_prev_we  = (r_bnext < sfra_pkg::NIL);
                w_prev_wa  = r_bnext[SW-1:0];
                w_prev_wd  = r_left;
            end
            sfra_pkg::CMD_R_MERGE: begin
                w_bytes_we = 1'b1; w_bytes_wd = w_rsum;
                w_next_we  = 1'b1; w_next_wd  = r_rn;
                w_prev_we  = (r_rn < sfra_pkg::NIL);
                w_prev_wa  = r_rn[SW-1:0];
                w_prev_wd  = LW'(r_b);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_bytes_we) mem_bytes[w_bytes_wa] <= w_bytes_wd;
        if (w_prev_we)  mem_prev[w_prev_wa]   <= w_prev_wd;
        if (w_next_we)  mem_next[w_next_wa]   <= w_next_wd;
        if (w_link_we)  mem_link[w_link_wa]   <= w_link_wd;
        if (w_free_we)  mem_free[w_free_wa]   <= w_free_wd;
        r_rd_bytes <= mem_bytes[w_ra];
        r_rd_prev  <= mem_prev[w_ra];
        r_rd_next  <= mem_next[w_ra];
        r_rd_link  <= mem_link[w_ra];
        r_rd_free  <= mem_free[w_ra];
    end

    // Control state: formatting flag, bin heads and the result slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready  <= 1'b0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < sfra_pkg::BIN_COUNT; i++) begin
                r_heads[i] <= sfra_pkg::NIL;
            end
        end else begin
            if (i_cmd == sfra_pkg::CMD_EMIT) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            case (i_cmd)
                sfra_pkg::CMD_FORMAT: begin
                    r_ready <= 1'b1;
                    for (int i = 0; i < sfra_pkg::BIN_COUNT; i++) begin
                        r_heads[i] <= sfra_pkg::NIL;
                    end
                    r_heads[sfra_pkg::bin_of(NW'(sfra_pkg::REGION_BYTES - sfra_pkg::POFF))]
                        <= '0;
                end
                sfra_pkg::CMD_UL_HIT: begin
                    if (r_before >= sfra_pkg::NIL) begin
                        r_heads[r_k[sfra_pkg::BIN_W-1:0]] <= r_rd_link;
                    end
                end
                sfra_pkg::CMD_PUSH: begin
                    r_heads[w_k_push] <= LW'(r_b);
                end
                default: begin
                end
            endcase
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            sfra_pkg::CMD_LOAD: begin
                r_func     <= i_func;
                r_req_zero <= (i_req == '0);
                r_need     <= w_need;
                r_b        <= SW'(w_off_rel >> sfra_pkg::ALIGN_SH);
                r_free_ok  <= r_ready && (i_off >= sfra_pkg::OFF_W'(sfra_pkg::POFF))
                              && (w_off_rel[sfra_pkg::ALIGN_SH-1:0] == '0)
                              && ((w_off_rel >> sfra_pkg::ALIGN_SH)
                                  < sfra_pkg::OFF_W'(sfra_pkg::SLOTS));
                r_status   <= sfra_pkg::STAT_DONE;
                r_hoff     <= '0;
            end
            sfra_pkg::CMD_SEEK_INIT: begin
                r_k     <= sfra_pkg::KCNT_W'(w_k_need);
                r_cur   <= r_heads[w_k_need];
                r_steps <= '0;
            end
            sfra_pkg::CMD_SEEK_BIN: begin
                r_k     <= r_k + 1'b1;
                r_cur   <= r_heads[r_k[sfra_pkg::BIN_W-1:0] + 1'b1];
                r_steps <= '0;
            end
            sfra_pkg::CMD_SEEK_ADV: begin
                r_cur   <= r_rd_link;
                r_steps <= r_steps + 1'b1;
            end
            sfra_pkg::CMD_FOUND: begin
                r_b     <= r_cur[SW-1:0];
                r_bb    <= r_rd_bytes;
                r_bnext <= r_rd_next;
                r_x     <= r_cur;
                r_xs    <= r_rd_bytes;
                r_hoff  <= sfra_pkg::OFF_W'((32'(r_cur[SW-1:0]) << sfra_pkg::ALIGN_SH)
                                            + 32'(sfra_pkg::POFF));
            end
            sfra_pkg::CMD_UL_INIT: begin
                r_k      <= sfra_pkg::KCNT_W'(w_k_ul);
                r_before <= sfra_pkg::NIL;
                r_cur    <= r_heads[w_k_ul];
                r_steps  <= '0;
            end
            sfra_pkg::CMD_UL_ADV: begin
                r_before <= r_cur;
                r_cur    <= r_rd_link;
                r_steps  <= r_steps + 1'b1;
            end
            sfra_pkg::CMD_CARVE_FIX: begin
                r_b  <= w_nb;
                r_bb <= w_nb_size;
            end
            sfra_pkg::CMD_F_MARK: begin
                r_bb    <= r_rd_bytes;
                r_bnext <= r_rd_next;
                r_left  <= r_rd_prev;
            end
            sfra_pkg::CMD_L_TAKE: begin
                r_x  <= r_left;
                r_xs <= r_rd_bytes;
            end
            sfra_pkg::CMD_L_MERGE: begin
                r_b  <= r_left[SW-1:0];
                r_bb <= w_lsum;
            end
            sfra_pkg::CMD_R_TAKE: begin
                r_x  <= r_bnext;
                r_xs <= r_rd_bytes;
                r_rn <= r_rd_next;
            end
            sfra_pkg::CMD_R_MERGE: begin
                r_bb    <= w_rsum;
                r_bnext <= r_rn;
            end
            sfra_pkg::CMD_RES_ZERO:  r_status <= sfra_pkg::STAT_ZERO;
            sfra_pkg::CMD_RES_NOFIT: r_status <= sfra_pkg::STAT_NOFIT;
            sfra_pkg::CMD_EMIT: begin
                r_ostat <= r_status;
                r_ohoff <= r_hoff;
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_ovalid;
    assign o_status    = r_ostat;
    assign o_hoff      = r_ohoff;

endmodule

// File: hw/rtl/segregated_fit_region_allocator_top.sv
// Top level of the segregated-fit region allocator: stream ports, controller and datapath.
//
// Channel    Direction  Bits  Contents
// s_axis     in         48    tdata: request_bytes[31:0], release_offset[47:32]; tuser: func
// m_axis     out        24    tdata: status[1:0], header_offset[17:2], zero fill above
//
// One transaction is worked on at a time. An allocate sets up, then walks the free list of
// the needed bin node by node, moving on to the next bin when a list ends, and then walks
// the bin of the chosen block again to unlink it.
// A free reads the block and walks the bin of each free neighbour to unlink it before merging.
// Every list walk steps through the single read port of the block record memories.
// Reset is synchronous and active low; it clears the formatted flag, the bin heads and the
// result slot. The record memories need no clearing. The result waits in an output register,
// so a stalled m_axis does not stop the next transaction from being accepted.
module segregated_fit_region_allocator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // request_bytes[31:0], release_offset[47:32]
    input  logic        s_axis_tuser,   // func[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // status[1:0], header_offset[17:2], zeros[23:18]
);

    sfra_pkg::t_cmd w_cmd;
    sfra_pkg::t_sts w_sts;
    logic [sfra_pkg::STAT_W-1:0] w_status;
    logic [sfra_pkg::OFF_W-1:0]  w_hoff;

    // The controller sequences every transaction; the datapath owns all storage.
    sfra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_sts      (w_sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    sfra_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_func      (s_axis_tuser),
        .i_req       (s_axis_tdata[31:0]),
        .i_off       (s_axis_tdata[47:32]),
        .i_out_ready (m_axis_tready),
        .o_sts       (w_sts),
        .o_out_valid (m_axis_tvalid),
        .o_status    (w_status),
        .o_hoff      (w_hoff)
    );

    assign m_axis_tdata = {6'd0, w_hoff, w_status};

    // Only one transaction is in flight, so input is refused right after an accept.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while a transaction was in progress");

    // A failed allocate never reports an offset.
    a_err_no_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[1:0] != sfra_pkg::STAT_DONE))
            |-> (m_axis_tdata[17:2] == '0))
        else $error("error status with a nonzero header offset");

    // Only the three defined status codes are produced.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] == sfra_pkg::STAT_DONE
                           || m_axis_tdata[1:0] == sfra_pkg::STAT_ZERO
                           || m_axis_tdata[1:0] == sfra_pkg::STAT_NOFIT))
        else $error("undefined status code");

    // A handed-out header always lies past the block header on an alignment step.
    a_offset_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[1:0] == sfra_pkg::STAT_DONE)
            && (m_axis_tdata[17:2] != '0))
            |-> (m_axis_tdata[2 +: sfra_pkg::ALIGN_SH] == '0))
        else $error("header offset off the alignment grid");

endmodule
